// ----- rtl/skrl_pkg.sv -----
// Shared types and codes for the sorted keyed record list.
// Used by skrl_cell and the sorted_keyed_record_list top level; no dependencies.
`timescale 1ns / 1ps

package skrl_pkg;

   // Request opcodes
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_DEL  = 2'd1;
   localparam logic [1:0] OP_DUMP = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_DELETED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_DUMP      = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;

   // Cell commands
   localparam logic [2:0] CELL_HOLD = 3'd0;
   localparam logic [2:0] CELL_INS  = 3'd1;
   localparam logic [2:0] CELL_DEL  = 3'd2;
   localparam logic [2:0] CELL_UPD  = 3'd3;
   localparam logic [2:0] CELL_ROT  = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] key_day;
      logic [31:0] low_value;
      logic [31:0] high_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_day;
      logic [31:0] out_low;
      logic [31:0] out_high;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key;
      logic [31:0] low;
      logic [31:0] high;
   } rec_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic [2:0] cmd;
      rec_type    rec;
   } cell_ctrl_type;

endpackage

// ----- rtl/skrl_cell.sv -----
// One storage cell of the sorted record chain: holds a record, compares its key.
// Depends on skrl_pkg.
`timescale 1ns / 1ps

module skrl_cell (
   input  logic                   clock,
   input  skrl_pkg::cell_ctrl_type ctrl,
   input  logic                   occ,
   input  logic                   tail,
   input  logic                   prev_lt,
   input  skrl_pkg::rec_type      prev_rec,
   input  skrl_pkg::rec_type      next_rec,
   input  skrl_pkg::rec_type      head_rec,
   output logic                   lt,
   output logic                   eq,
   output skrl_pkg::rec_type      rec
);
   import skrl_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;

   // Compare the held key with the broadcast key
   assign lt  = occ && (rec_ff.key < ctrl.rec.key);
   assign eq  = occ && (rec_ff.key == ctrl.rec.key);
   assign rec = rec_ff;

   // Pick the next content from the neighbors, the head cell or the broadcast record
   always_comb begin
      rec_in = rec_ff;
      case (ctrl.cmd)
         CELL_INS: begin
            if (!prev_lt) begin
               rec_in = prev_rec;
            end else if (!lt) begin
               rec_in = ctrl.rec;
            end
         end
         CELL_DEL: begin
            if (!lt) begin
               rec_in = next_rec;
            end
         end
         CELL_UPD: begin
            if (eq) begin
               rec_in.low  = ctrl.rec.low;
               rec_in.high = ctrl.rec.high;
            end
         end
         CELL_ROT: begin
            rec_in = tail ? head_rec : next_rec;
         end
         default: begin
            rec_in = rec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ----- rtl/sorted_keyed_record_list.sv -----
// Top level of the sorted keyed record list: controller and chain of cells.
// Depends on skrl_pkg and skrl_cell.
`timescale 1ns / 1ps

// Keeps up to CAPACITY records (16-bit key, two 32-bit words) in ascending key
// order in a row of cells that compare against a broadcast key in parallel.
// Add, update and delete first register the request, then the cells compare
// and shift while the result is loaded into the output register. A dump
// streams one record per cycle out of the head cell, while the result side
// is not stalled, as the occupied cells rotate, so it keeps the request side
// busy until the last record is loaded and leaves the order intact.
// The request side is ready again as soon as the result is in the output
// register; a stalled result side holds the block in that last step.

module sorted_keyed_record_list #(
   parameter int CAPACITY = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skrl_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skrl_pkg::rsp_type rsp_payload
);
   import skrl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dump_left_ff, dump_left_in;
   req_type          cmd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cell_ctrl_type    ctrl;
   logic [2:0]       cell_cmd;
   logic             out_free;
   logic             found;
   logic             full;

   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;
   rec_type             rec_vec [CAPACITY];

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign found    = |eq_vec;
   assign full     = (count_ff == CNT_W'(CAPACITY));

   assign ctrl.cmd       = cell_cmd;
   assign ctrl.rec.key   = cmd_ff.key_day;
   assign ctrl.rec.low   = cmd_ff.low_value;
   assign ctrl.rec.high  = cmd_ff.high_value;

   // Build the chain of cells
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic    occ;
         logic    tail;
         logic    prev_lt;
         rec_type prev_rec;
         rec_type next_rec;

         assign occ  = (count_ff > CNT_W'(gi));
         assign tail = (count_ff == CNT_W'(gi + 1));

         if (gi == 0) begin : g_head
            assign prev_lt  = 1'b1;
            assign prev_rec = rec_vec[0];
         end else begin : g_body
            assign prev_lt  = lt_vec[gi-1];
            assign prev_rec = rec_vec[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_end
            assign next_rec = rec_vec[gi];
         end else begin : g_mid
            assign next_rec = rec_vec[gi+1];
         end

         skrl_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .occ      (occ),
            .tail     (tail),
            .prev_lt  (prev_lt),
            .prev_rec (prev_rec),
            .next_rec (next_rec),
            .head_rec (rec_vec[0]),
            .lt       (lt_vec[gi]),
            .eq       (eq_vec[gi]),
            .rec      (rec_vec[gi])
         );
      end
   endgenerate

   // Sequence requests, drive the cells and load the result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      cell_cmd     = CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in             = S_IDLE;
               rsp_data_in          = '0;
               rsp_data_in.out_day  = cmd_ff.key_day;
               rsp_data_in.last     = 1'b1;
               case (cmd_ff.opcode)
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        cell_cmd           = CELL_UPD;
                        rsp_data_in.status = ST_UPDATED;
                     end else if (full) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        cell_cmd           = CELL_INS;
                        count_in           = count_ff + CNT_W'(1);
                        rsp_data_in.status = ST_INSERTED;
                     end
                  end
                  OP_DEL: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        cell_cmd           = CELL_DEL;
                        count_in           = count_ff - CNT_W'(1);
                        rsp_data_in.status = ST_DELETED;
                     end else begin
                        rsp_data_in.status = ST_NOT_FOUND;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in        = 1'b1;
                        rsp_data_in.status  = ST_EMPTY;
                        rsp_data_in.out_day = '0;
                     end else begin
                        rsp_data_in  = rsp_data_ff;
                        dump_left_in = count_ff;
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                     rsp_data_in = rsp_data_ff;
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               cell_cmd             = CELL_ROT;
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = ST_DUMP;
               rsp_data_in.out_day  = rec_vec[0].key;
               rsp_data_in.out_low  = rec_vec[0].low;
               rsp_data_in.out_high = rec_vec[0].high;
               rsp_data_in.last     = (dump_left_ff == CNT_W'(1));
               dump_left_in         = dump_left_ff - CNT_W'(1);
               if (dump_left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_payload;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Record count stays within the chain
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("record count above capacity");

   // A dump in progress always has records left to send
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (dump_left_ff != '0))
      else $error("dump state with nothing left");

   // An insert grows the store by exactly one record
   assert property (@(posedge clock) disable iff (reset)
      (cell_cmd == CELL_INS) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the store");

   // No result is loaded over one that the consumer has not taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && (state_ff != S_IDLE)) |=> $stable(rsp_data_ff))
      else $error("stalled result overwritten");

endmodule

// ----- tb/skrl_reply_checker.sv -----
// Reply checker for the sorted keyed record list: watches both channels,
// keeps a shadow copy of the sorted store and checks every reply beat.
// Depends on skrl_pkg.
`timescale 1ns / 1ps

module skrl_reply_checker #(
   parameter int CAPACITY = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  skrl_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  skrl_pkg::rsp_type rsp_payload,
   output logic [31:0]       fail_count,
   output logic [31:0]       owed_count,
   output logic [31:0]       checked_count,
   output logic [6:0]        status_seen
);

   import skrl_pkg::*;

   // Shadow store: only the first shadow_count entries are meaningful
   rec_type     shadow_recs [CAPACITY];
   int          shadow_count = 0;
   rsp_type     owed_replies [$];
   int          errors = 0;
   int          checked = 0;
   logic [6:0]  seen = '0;

   assign fail_count    = errors;
   assign checked_count = checked;
   assign status_seen   = seen;

   function automatic rsp_type make_reply(input logic [2:0] status, input logic [15:0] day,
                                          input logic [31:0] lo, input logic [31:0] hi,
                                          input logic last);
      rsp_type r;
      r.status   = status;
      r.out_day  = day;
      r.out_low  = lo;
      r.out_high = hi;
      r.last     = last;
      return r;
   endfunction

   // Apply one accepted command to the shadow store and queue its replies
   task automatic model_list_command(input req_type beat);
      int      pos;
      int      i;
      bit      hit;
      rec_type fresh;
      pos = 0;
      while (pos < shadow_count && shadow_recs[pos].key < beat.key_day) pos++;
      hit = (pos < shadow_count) && (shadow_recs[pos].key == beat.key_day);
      fresh.key  = beat.key_day;
      fresh.low  = beat.low_value;
      fresh.high = beat.high_value;
      case (beat.opcode)
         OP_ADD: begin
            if (hit) begin
               // Existing key: overwrite payload, even when full
               shadow_recs[pos] = fresh;
               owed_replies.push_back(make_reply(ST_UPDATED, beat.key_day, '0, '0, 1'b1));
            end else if (shadow_count >= CAPACITY) begin
               owed_replies.push_back(make_reply(ST_FULL, beat.key_day, '0, '0, 1'b1));
            end else begin
               // Open a slot at the sorted place
               for (i = shadow_count; i > pos; i--) shadow_recs[i] = shadow_recs[i - 1];
               shadow_recs[pos] = fresh;
               shadow_count++;
               owed_replies.push_back(make_reply(ST_INSERTED, beat.key_day, '0, '0, 1'b1));
            end
         end
         OP_DEL: begin
            if (hit) begin
               // Close the gap left by the removed record
               for (i = pos; i + 1 < shadow_count; i++) shadow_recs[i] = shadow_recs[i + 1];
               shadow_count--;
               owed_replies.push_back(make_reply(ST_DELETED, beat.key_day, '0, '0, 1'b1));
            end else begin
               owed_replies.push_back(make_reply(ST_NOT_FOUND, beat.key_day, '0, '0, 1'b1));
            end
         end
         OP_DUMP: begin
            if (shadow_count == 0) begin
               owed_replies.push_back(make_reply(ST_EMPTY, '0, '0, '0, 1'b1));
            end else begin
               for (i = 0; i < shadow_count; i++)
                  owed_replies.push_back(make_reply(ST_DUMP, shadow_recs[i].key,
                                                    shadow_recs[i].low, shadow_recs[i].high,
                                                    i + 1 == shadow_count));
            end
         end
         default: begin
            // Unused opcode: no reply, store untouched
         end
      endcase
   endtask

   // Sample both channels at the edge; predict first, then check
   always @(posedge clock) begin : watch
      rsp_type want;
      string   diffs;
      if (reset) begin
         shadow_count = 0;
      end else begin
         if (req_valid && req_ready) model_list_command(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               errors++;
               $display({"%0t: unexpected reply beat, expected none, ",
                         "actual status %0d day %h low %h high %h last %b"},
                        $time, rsp_payload.status, rsp_payload.out_day, rsp_payload.out_low,
                        rsp_payload.out_high, rsp_payload.last);
            end else begin
               want  = owed_replies.pop_front();
               diffs = "";
               if (rsp_payload.status !== want.status) diffs = {diffs, " status"};
               if (rsp_payload.out_day !== want.out_day) diffs = {diffs, " out_day"};
               if (rsp_payload.out_low !== want.out_low) diffs = {diffs, " out_low"};
               if (rsp_payload.out_high !== want.out_high) diffs = {diffs, " out_high"};
               if (rsp_payload.last !== want.last) diffs = {diffs, " last"};
               if (diffs != "") begin
                  errors++;
                  $display({"%0t: reply mismatch in%s: ",
                            "expected status %0d day %h low %h high %h last %b"},
                           $time, diffs, want.status, want.out_day, want.out_low,
                           want.out_high, want.last);
                  $display("%0t:   actual status %0d day %h low %h high %h last %b",
                           $time, rsp_payload.status, rsp_payload.out_day,
                           rsp_payload.out_low, rsp_payload.out_high, rsp_payload.last);
               end
               checked++;
               if (rsp_payload.status <= ST_EMPTY) seen[rsp_payload.status] = 1'b1;
            end
         end
      end
      // Publish how many reply beats are still expected
      owed_count <= owed_replies.size();
   end

endmodule

// ----- tb/sorted_keyed_record_list_test.sv -----
// Top of the sorted keyed record list testbench: clock, reset, command stimulus,
// reply-side backpressure and the verdict. Depends on skrl_pkg, the block and
// skrl_reply_checker.
`timescale 1ns / 1ps

module sorted_keyed_record_list_test;

   import skrl_pkg::*;

   localparam int          CAPACITY   = 32;
   localparam int          POOL_SIZE  = 40;
   localparam int          RANDOM_TARGET = 365;
   localparam logic [1:0]  OP_UNUSED  = 2'd3;

   typedef enum int {ROUND_MIXED, ROUND_FILL, ROUND_DRAIN} round_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;

   logic [31:0] fail_count;
   logic [31:0] owed_count;
   logic [31:0] checked_count;
   logic [6:0]  status_seen;

   logic [15:0] key_pool [POOL_SIZE];
   int          sent_beats = 0;
   int          ignored_beats = 0;
   int          random_sent = 0;

   sorted_keyed_record_list #(.CAPACITY(CAPACITY)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   skrl_reply_checker #(.CAPACITY(CAPACITY)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .owed_count    (owed_count),
      .checked_count (checked_count),
      .status_seen   (status_seen)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Reply-side backpressure: calm stretches, short stalls, the odd long one
   int stall_left = 0;
   int phase_left = 0;
   bit calm_phase = 1'b0;
   always @(posedge clock) begin
      if (phase_left == 0) begin
         calm_phase = ($urandom_range(0, 3) == 0);
         phase_left = $urandom_range(50, 300);
      end else begin
         phase_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(8, 30);
      end
      rsp_ready <= reset ? 1'b0 : (stall_left == 0);
   end

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic req_type make_command(input logic [1:0] op, input logic [15:0] key);
      req_type c;
      c.opcode     = op;
      c.key_day    = key;
      c.low_value  = $urandom;
      c.high_value = $urandom;
      return c;
   endfunction

   // Present one command beat after an idle gap and hold it until accepted
   task automatic send_command(input req_type beat, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_beats++;
      if (beat.opcode == OP_UNUSED) ignored_beats++;
   endtask

   task automatic send_with_payload(input logic [1:0] op, input logic [15:0] key,
                                    input logic [31:0] lo, input logic [31:0] hi);
      req_type c;
      c.opcode     = op;
      c.key_day    = key;
      c.low_value  = lo;
      c.high_value = hi;
      send_command(c, pick_gap(1'b0));
   endtask

   // Random rounds of well-formed sequences plus noise
   task automatic run_round(input round_kind_type kind, input bit calm);
      int          i;
      int          r;
      int          start;
      logic [1:0]  op;
      logic [15:0] key;
      start = $urandom_range(0, POOL_SIZE - 1);
      case (kind)
         ROUND_FILL: begin
            // Enough distinct keys to reach capacity, then hit the full store
            for (i = 0; i < POOL_SIZE; i++)
               send_command(make_command(OP_ADD, key_pool[(start + i) % POOL_SIZE]),
                            pick_gap(calm));
            send_command(make_command(OP_ADD, 16'($urandom_range(0, 65535))), pick_gap(calm));
            send_command(make_command(OP_ADD, key_pool[start]), pick_gap(calm));
            send_command(make_command(OP_DUMP, 16'($urandom_range(0, 65535))), pick_gap(calm));
            random_sent += POOL_SIZE + 3;
         end
         ROUND_DRAIN: begin
            // Stride 7 visits every pool key once in scrambled order
            for (i = 0; i < POOL_SIZE; i++)
               send_command(make_command(OP_DEL, key_pool[(start + i * 7) % POOL_SIZE]),
                            pick_gap(calm));
            send_command(make_command(OP_DEL, 16'($urandom_range(0, 65535))), pick_gap(calm));
            send_command(make_command(OP_DUMP, 16'($urandom_range(0, 65535))), pick_gap(calm));
            random_sent += POOL_SIZE + 2;
         end
         default: begin
            for (i = 0; i < 30; i++) begin
               r = $urandom_range(0, 99);
               op = (r < 45) ? OP_ADD : (r < 80) ? OP_DEL : (r < 95) ? OP_DUMP : OP_UNUSED;
               key = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : 16'($urandom_range(0, 65535));
               send_command(make_command(op, key), pick_gap(calm));
               if (op != OP_UNUSED) random_sent++;
            end
         end
      endcase
   endtask

   initial begin : stimulus
      int r;
      round_kind_type kind;
      key_pool[0] = 16'h0000;
      key_pool[POOL_SIZE - 1] = 16'hFFFF;
      for (int i = 1; i < POOL_SIZE - 1; i++)
         key_pool[i] = 16'(i * 1680 + $urandom_range(0, 1000));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, key and payload extremes, update, head/middle/tail delete
      send_command(make_command(OP_DUMP, 16'h0000), 0);
      send_command(make_command(OP_DEL, 16'h1234), pick_gap(1'b0));
      send_with_payload(OP_UNUSED, 16'h5555, '0, '0);
      send_with_payload(OP_ADD, 16'h8000, 32'h0000_0000, 32'h0000_0000);
      send_with_payload(OP_ADD, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_with_payload(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_with_payload(OP_ADD, 16'h7FFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_command(make_command(OP_ADD, 16'h8001), pick_gap(1'b0));
      send_with_payload(OP_ADD, 16'h8000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_command(make_command(OP_DUMP, 16'hFFFF), pick_gap(1'b0));
      send_command(make_command(OP_DEL, 16'h7FFE), pick_gap(1'b0));
      send_command(make_command(OP_DEL, 16'h0000), pick_gap(1'b0));
      send_command(make_command(OP_DEL, 16'hFFFF), pick_gap(1'b0));
      send_command(make_command(OP_DEL, 16'h8000), pick_gap(1'b0));
      send_with_payload(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_command(make_command(OP_DUMP, 16'h0000), pick_gap(1'b0));
      send_command(make_command(OP_DEL, 16'h7FFF), pick_gap(1'b0));
      send_command(make_command(OP_DEL, 16'h8001), pick_gap(1'b0));
      send_command(make_command(OP_DUMP, 16'h0000), pick_gap(1'b0));
      send_command(make_command(OP_ADD, 16'h0001), 0);
      send_command(make_command(OP_DUMP, 16'h0000), 0);
      send_command(make_command(OP_DEL, 16'h0001), 0);

      // Random part: start with a fill so the full store is reached early
      run_round(ROUND_FILL, 1'b0);
      while (random_sent < RANDOM_TARGET) begin
         r = $urandom_range(0, 99);
         kind = (r < 50) ? ROUND_MIXED : (r < 75) ? ROUND_FILL : ROUND_DRAIN;
         run_round(kind, $urandom_range(0, 3) == 0);
      end
      req_valid <= 1'b0;

      // Drain outstanding replies, then watch a quiet tail for strays
      @(posedge clock);
      while (owed_count != 0) @(negedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d command beats (%0d with the unused opcode).",
               sent_beats, ignored_beats);
      $display("%0d reply beats checked; status codes seen, inserted up to dump empty: %b",
               checked_count, status_seen);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #15_000_000;
      $display("Timeout with %0d replies still owed", owed_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/skrl_pkg.sv
rtl/skrl_cell.sv
rtl/sorted_keyed_record_list.sv
tb/skrl_reply_checker.sv
tb/sorted_keyed_record_list_test.sv
